/* design/fcct_pkg.sv */
// shared types, constants and helpers of the four-channel counter/timer
// no dependencies

package fcct_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;

  typedef logic [CH_W-1:0] ch_t;

  // request kinds
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;
  localparam logic [1:0] MODE_ACK     = 2'd3;

  // control byte bit positions
  localparam int CTL_IRQ_EN   = 7;
  localparam int CTL_COUNTER  = 6;
  localparam int CTL_PRE256   = 5;
  localparam int CTL_NO_WAIT  = 4;
  localparam int CTL_TC_NEXT  = 2;
  localparam int CTL_STOPPED  = 1;
  localparam int CTL_CTL_WORD = 0;

  localparam logic [7:0] CTL_LOAD_MASK = 8'hf9;
  localparam logic [7:0] VEC_MASK      = 8'hf8;
  localparam logic [8:0] TC_FULL       = 9'h100;
  localparam ch_t        PAIR_FLIP     = 2'd2;

  localparam int DIVIDEND_W = 13;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic [7:0]  ctl;
    logic [8:0]  tc;
    logic [15:0] residue;
  } entry_t;

  localparam entry_t ENTRY_RST = '{ctl: 8'h03, tc: TC_FULL, residue: 16'h0000};

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [8:0]            divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
    logic [7:0]            rem;
  } div_rsp_t;

  typedef struct packed {
    logic [7:0]  irq_vector;
    logic [12:0] zero_crossings;
    logic [8:0]  read_value;
    logic        irq_valid;
  } result_t;

  function automatic entry_t load_const(entry_t ent, logic [7:0] data);
    entry_t r;
    r         = ent;
    r.tc      = (data == 8'h00) ? TC_FULL : {1'b0, data};
    r.residue = 16'h0000;
    r.ctl     = ent.ctl & CTL_LOAD_MASK;
    return r;
  endfunction

endpackage

/* design/fcct_ram.sv */
// per-channel state memory, one write and one registered read port
// entries never written read as the reset value; uses fcct_pkg

module fcct_ram import fcct_pkg::*; #(
  parameter int               WIDTH   = 33,
  parameter logic [WIDTH-1:0] RST_VAL = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  ch_t              wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  ch_t              rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0]    mem [CHANNELS];
  logic [WIDTH-1:0]    q_r;
  logic [CHANNELS-1:0] valid_r;
  logic                qv_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      qv_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      qv_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = qv_r ? q_r : RST_VAL;

endmodule

/* design/fcct_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
// uses fcct_pkg

module fcct_div import fcct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVIDEND_W-1:0] num_r;
  logic [7:0]            rem_r;
  logic [8:0]            dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  done_r;
  logic [8:0]            trial;
  logic                  fits;
  logic [8:0]            diff;

  assign trial = {rem_r, num_r[DIVIDEND_W-1]};
  assign fits  = (trial >= dvs_r);
  assign diff  = trial - dvs_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      rem_r <= 8'h00;
      dvs_r <= req.divisor;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? diff[7:0] : trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;
  assign rsp.rem  = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < dvs_r))
    else $error("divider remainder not below divisor");

  a_start_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (cnt_r == DIV_CNT_W'(DIV_STEPS)))
    else $error("divider did not load its step count");

endmodule

/* design/four_channel_counter_timer_top.sv */
// four-channel counter/timer top: request sequencer over the channel memories
// steps: write, read and acknowledge finish after the memory read; a paired constant
// load then loads the partner channel; advance runs memory read, 13-step serial divide,
// done step; one request at a time, the next taken once its result is registered;
// a hold stage behind the result register lets a new request in while a result waits
// reset: all channels stopped, constant 256, nothing pending, vector base 0.

module four_channel_counter_timer_top import fcct_pkg::*; #(
  parameter int PENDING_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // paired_constant_load
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,       // channel, write_data, system_clocks, trigger_pulses
  input  logic [1:0]  in_tuser,       // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,      // read_value, zero_crossings, irq_vector
  output logic        out_tuser       // irq_valid
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_PAIR = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;

  localparam int SUM_W = ((PENDING_WIDTH > DIVIDEND_W) ? PENDING_WIDTH : DIVIDEND_W) + 1;
  localparam logic [PENDING_WIDTH-1:0] PEND_MAX = {PENDING_WIDTH{1'b1}};

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  mode_r;
  ch_t         ch_r;
  logic [7:0]  data_r;
  logic [15:0] sys_r;
  logic [7:0]  pul_r;
  logic        hit_r;
  logic [7:0]  lo_r;
  logic        paired_r;
  logic [7:0]  vbase_r;
  logic [CHANNELS-1:0] pend_nz_r;

  logic        in_acc;
  logic [1:0]  in_mode;
  ch_t         in_ch;
  ch_t         ack_ch;
  logic        ack_hit;

  ch_t                      rd_addr;
  ch_t                      wr_addr;
  entry_t                   ent_q;
  entry_t                   ent_wd;
  logic                     ent_we;
  logic [PENDING_WIDTH-1:0] pend_q;
  logic [PENDING_WIDTH-1:0] pend_wd;
  logic                     pend_we;
  logic                     vb_we;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [8:0]  tc_eff;
  logic [19:0] clocks;
  logic [20:0] clk_sum;
  logic        adv_skip;
  logic [16:0] full;
  logic [16:0] left;
  logic [SUM_W-1:0] pend_sum;

  logic    fin;
  result_t fin_res;
  result_t out_r, hold_r;
  logic    out_v_r, hold_v_r;
  logic    out_free;

  assign in_mode = in_tuser;
  assign in_ch   = in_tdata[1:0];
  assign in_acc  = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !hold_v_r;

  always_comb begin
    ack_ch  = '0;
    ack_hit = 1'b0;
    for (int k = CHANNELS - 1; k >= 0; k--) begin
      if (pend_nz_r[k]) begin
        ack_ch  = ch_t'(k);
        ack_hit = 1'b1;
      end
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = (in_mode == MODE_ACK) ? ack_ch : in_ch;
      S_READ:  rd_addr = ch_r ^ PAIR_FLIP;
      default: rd_addr = ch_r;
    endcase
  end

  fcct_ram #(
    .WIDTH   ($bits(entry_t)),
    .RST_VAL (ENTRY_RST)
  ) u_ent_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ent_we),
    .wr_addr (wr_addr),
    .wr_data (ent_wd),
    .rd_addr (rd_addr),
    .rd_data (ent_q)
  );

  fcct_ram #(
    .WIDTH   (PENDING_WIDTH),
    .RST_VAL ('0)
  ) u_pend_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (pend_we),
    .wr_addr (wr_addr),
    .wr_data (pend_wd),
    .rd_addr (rd_addr),
    .rd_data (pend_q)
  );

  fcct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // advance arithmetic
  assign tc_eff = ((ent_q.tc == 9'h000) || (ent_q.tc > TC_FULL)) ? TC_FULL : ent_q.tc;

  always_comb begin
    if (ent_q.ctl[CTL_COUNTER]) begin
      clocks = {4'h0, pul_r, 8'h00};
    end else if (ent_q.ctl[CTL_PRE256]) begin
      clocks = {4'h0, sys_r};
    end else begin
      clocks = {sys_r, 4'h0};
    end
  end

  assign clk_sum  = {1'b0, clocks} + {5'h00, ent_q.residue};
  assign adv_skip = ent_q.ctl[CTL_STOPPED]
                 || (!ent_q.ctl[CTL_COUNTER] && !ent_q.ctl[CTL_NO_WAIT] && (pul_r == 8'h00))
                 || (clocks == 20'h00000);

  assign full     = {ent_q.tc, 8'h00};
  assign left     = full - {1'b0, ent_q.residue};
  assign pend_sum = SUM_W'(pend_q) + SUM_W'(div_rsp.quot);

  always_comb begin
    state_nxt = state_r;
    ent_we    = 1'b0;
    ent_wd    = ent_q;
    pend_we   = 1'b0;
    pend_wd   = pend_q;
    wr_addr   = ch_r;
    vb_we     = 1'b0;
    fin       = 1'b0;
    fin_res   = '0;
    div_req   = '{start: 1'b0, dividend: clk_sum[20:8], divisor: tc_eff};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        case (mode_r)
          MODE_WRITE: begin
            if (ent_q.ctl[CTL_TC_NEXT]) begin
              ent_we = 1'b1;
              ent_wd = load_const(ent_q, data_r);
              if (paired_r) begin
                state_nxt = S_PAIR;
              end else begin
                fin       = 1'b1;
                state_nxt = S_IDLE;
              end
            end else begin
              if (data_r[CTL_CTL_WORD]) begin
                ent_we     = 1'b1;
                ent_wd.ctl = data_r;
              end else if (!ch_r[1]) begin
                vb_we = 1'b1;
              end
              fin       = 1'b1;
              state_nxt = S_IDLE;
            end
          end

          MODE_READ: begin
            fin                = 1'b1;
            fin_res.read_value = ({1'b0, ent_q.residue} >= full) ? 9'h000 : left[16:8];
            state_nxt          = S_IDLE;
          end

          MODE_ADVANCE: begin
            if (adv_skip) begin
              fin       = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end

          default: begin
            if (hit_r) begin
              pend_we            = 1'b1;
              pend_wd            = pend_q - 1'b1;
              fin_res.irq_vector = vbase_r + {5'h00, ch_r, 1'b0};
              fin_res.irq_valid  = 1'b1;
            end
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_PAIR: begin
        wr_addr = ch_r ^ PAIR_FLIP;
        if (ent_q.ctl[CTL_TC_NEXT]) begin
          ent_we = 1'b1;
          ent_wd = load_const(ent_q, data_r);
        end
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end

      S_DIV: begin
        if (div_rsp.done) begin
          ent_we         = 1'b1;
          ent_wd.residue = {div_rsp.rem, lo_r};
          if ((div_rsp.quot != '0) && ent_q.ctl[CTL_IRQ_EN]) begin
            pend_we = 1'b1;
            pend_wd = (pend_sum > SUM_W'(PEND_MAX)) ? PEND_MAX : pend_sum[PENDING_WIDTH-1:0];
          end
          fin                    = 1'b1;
          fin_res.zero_crossings = div_rsp.quot;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // request capture and payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      ch_r   <= (in_mode == MODE_ACK) ? ack_ch : in_ch;
      hit_r  <= ack_hit;
      data_r <= in_tdata[9:2];
      sys_r  <= in_tdata[25:10];
      pul_r  <= in_tdata[33:26];
    end
    if (state_r == S_READ) begin
      lo_r <= clk_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      paired_r  <= 1'b1;
      vbase_r   <= 8'h00;
      pend_nz_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        paired_r <= cfg_wr_data;
      end
      if (vb_we) begin
        vbase_r <= data_r & VEC_MASK;
      end
      if (pend_we) begin
        pend_nz_r[wr_addr] <= (pend_wd != '0);
      end
    end
  end

  // result register with one hold stage
  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (fin) begin
      if (out_free) begin
        out_r <= fin_res;
      end else begin
        hold_r <= fin_res;
      end
    end else if (out_tready && out_v_r && hold_v_r) begin
      out_r <= hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      if (fin) begin
        if (out_free) begin
          out_v_r <= 1'b1;
        end else begin
          hold_v_r <= 1'b1;
        end
      end else if (out_tready && out_v_r) begin
        if (hold_v_r) begin
          hold_v_r <= 1'b0;
        end else begin
          out_v_r <= 1'b0;
        end
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_r.irq_vector, out_r.zero_crossings, out_r.read_value};
  assign out_tuser  = out_r.irq_valid;

  a_hold_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> out_v_r)
    else $error("hold stage filled while result register empty");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("request taken while another is in progress");

  a_fin_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (state_r != S_IDLE) && !hold_v_r)
    else $error("result produced with no request in flight or hold stage full");

  a_irq_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.irq_valid) |-> (out_r.read_value == 9'h000)
                                     && (out_r.zero_crossings == 13'h0000))
    else $error("acknowledge result carries other fields");

endmodule

/* tb/sv/four_channel_counter_timer_top_test.sv */
// self-checking bench for the four-channel counter/timer: directed and random
// register writes, reads, advances and acknowledges against an in-bench predictor
// depends on fcct_pkg and four_channel_counter_timer_top

module four_channel_counter_timer_top_test import fcct_pkg::*;;

  localparam int PEND_W      = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_LATENCY = 20;

  typedef struct {
    logic [1:0]  mode;
    ch_t         chan;
    logic [7:0]  wdata;
    logic [15:0] sysclk;
    logic [7:0]  pulses;
  } ctc_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  // predicted channel state
  logic [7:0]        chan_ctl [CHANNELS];
  logic [8:0]        chan_tc [CHANNELS];
  logic [15:0]       chan_residue [CHANNELS];
  logic [PEND_W-1:0] irq_pending [CHANNELS];
  logic [7:0]        vec_base;
  bit                pair_load;

  result_t     ctc_replies [$];
  result_t     due;
  int unsigned bad_fields = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ready_hold = 0;
  bit          calm = 1'b0;

  four_channel_counter_timer_top #(.PENDING_WIDTH(PEND_W)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void load_timebase(ch_t ch, logic [7:0] data);
    chan_tc[ch]      = (data == 8'h00) ? TC_FULL : {1'b0, data};
    chan_residue[ch] = '0;
    chan_ctl[ch]     = chan_ctl[ch] & CTL_LOAD_MASK;
  endfunction

  function automatic result_t ctc_respond(ctc_req_t r);
    result_t     res;
    ch_t         other;
    logic [7:0]  ctl;
    logic [16:0] full;
    int unsigned clocks;
    int unsigned divisor;
    int unsigned xings;
    longint      sum;
    bit          found;
    res = '0;
    case (r.mode)
      MODE_WRITE: begin
        if (chan_ctl[r.chan][CTL_TC_NEXT]) begin
          other = r.chan ^ PAIR_FLIP;
          load_timebase(r.chan, r.wdata);
          if (pair_load && chan_ctl[other][CTL_TC_NEXT]) load_timebase(other, r.wdata);
        end else if (r.wdata[CTL_CTL_WORD]) begin
          chan_ctl[r.chan] = r.wdata;
        end else if (!r.chan[1]) begin
          vec_base = r.wdata & VEC_MASK;
        end
      end
      MODE_READ: begin
        full = {chan_tc[r.chan], 8'h00};
        if (chan_residue[r.chan] < full) res.read_value = 9'((full - chan_residue[r.chan]) >> 8);
      end
      MODE_ADVANCE: begin
        ctl = chan_ctl[r.chan];
        clocks = 0;
        if (!ctl[CTL_STOPPED]) begin
          if (ctl[CTL_COUNTER]) clocks = 32'({r.pulses, 8'h00});
          else if (ctl[CTL_NO_WAIT] || r.pulses != 0)
            clocks = ctl[CTL_PRE256] ? 32'({4'h0, r.sysclk}) : 32'({r.sysclk, 4'h0});
        end
        if (clocks != 0) begin
          divisor = 32'({chan_tc[r.chan], 8'h00});
          clocks  = clocks + 32'(chan_residue[r.chan]);
          xings   = clocks / divisor;
          chan_residue[r.chan] = 16'(clocks % divisor);
          if (xings != 0 && ctl[CTL_IRQ_EN]) begin
            sum = longint'(irq_pending[r.chan]) + xings;
            irq_pending[r.chan] = (sum > longint'({PEND_W{1'b1}})) ? {PEND_W{1'b1}}
                                                                     : PEND_W'(sum);
          end
          res.zero_crossings = 13'(xings);
        end
      end
      default: begin
        found = 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
          if (!found && irq_pending[k] != 0) begin
            found = 1'b1;
            irq_pending[k] = irq_pending[k] - 1'b1;
            res.irq_vector = 8'(vec_base + 2 * k);
            res.irq_valid  = 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic int unsigned pending_total();
    int unsigned t;
    t = 0;
    for (int k = 0; k < CHANNELS; k++) t += irq_pending[k];
    return t;
  endfunction

  function automatic ctc_req_t ctc_req(logic [1:0] mode, ch_t chan, logic [7:0] wdata,
                                       logic [15:0] sysclk, logic [7:0] pulses);
    ctc_req_t r;
    r.mode   = mode;
    r.chan   = chan;
    r.wdata  = wdata;
    r.sysclk = sysclk;
    r.pulses = pulses;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    bad_fields++;
    if (bad_fields <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send_request(ctc_req_t r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {6'd0, r.pulses, r.sysclk, r.wdata, r.chan};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ctc_replies.push_back(ctc_respond(r));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (ctc_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_pair_load(bit v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pair_load = v;
  endtask

  task automatic send_random_request();
    ctc_req_t    r;
    int unsigned pick;
    r = ctc_req(2'($urandom_range(0, 3)), ch_t'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // program a channel: control word with constant unless one is awaited, then the constant
      r.mode = MODE_WRITE;
      if (!chan_ctl[r.chan][CTL_TC_NEXT]) begin
        r.wdata[CTL_CTL_WORD] = 1'b1;
        r.wdata[CTL_TC_NEXT]  = 1'b1;
        r.wdata[CTL_STOPPED]  = ($urandom_range(0, 7) == 0);
        r.wdata[CTL_IRQ_EN]   = ($urandom_range(0, 2) == 0);
        send_request(r);
      end
      r.wdata = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_request(r);
    end else begin
      if (pick < 50) begin
        r.mode = MODE_ADVANCE;
        if ($urandom_range(0, 7) != 0) r.sysclk = 16'($urandom_range(0, 511));
        if ($urandom_range(0, 3) == 0) r.pulses = 8'h00;
      end else if (pick < 65) begin
        r.mode = MODE_READ;
      end else if (pick < 85) begin
        r.mode = MODE_ACK;
      end else if (pick < 92) begin
        r.mode = MODE_WRITE;
        r.wdata[CTL_CTL_WORD] = 1'b0;
      end
      send_request(r);
    end
  endtask

  task automatic test_reset_state();
    send_request(ctc_req(MODE_ACK, 2'd0, 8'h00, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_READ, 2'd0, 8'h00, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_ADVANCE, 2'd1, 8'h00, 16'hffff, 8'hff));
  endtask

  task automatic test_channel_programming();
    send_request(ctc_req(MODE_WRITE, 2'd0, 8'hfe, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd2, 8'h16, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd0, 8'h95, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd2, 8'hd5, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd0, 8'h00, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_ADVANCE, 2'd0, 8'h00, 16'hffff, 8'h00));
    send_request(ctc_req(MODE_ADVANCE, 2'd2, 8'h00, 16'h0000, 8'hff));
    send_request(ctc_req(MODE_READ, 2'd2, 8'h00, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd1, 8'h25, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd1, 8'h01, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_ADVANCE, 2'd1, 8'h00, 16'd500, 8'h00));
    send_request(ctc_req(MODE_ADVANCE, 2'd1, 8'h00, 16'hffff, 8'h01));
    send_request(ctc_req(MODE_READ, 2'd1, 8'h00, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_ACK, 2'd3, 8'h00, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_ADVANCE, 2'd0, 8'h00, 16'h0000, 8'h00));
  endtask

  task automatic test_paired_load();
    set_pair_load(1'b0);
    send_request(ctc_req(MODE_WRITE, 2'd1, 8'h05, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd3, 8'h05, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd1, 8'h80, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_READ, 2'd3, 8'h00, 16'h0000, 8'h00));
    set_pair_load(1'b1);
    send_request(ctc_req(MODE_WRITE, 2'd1, 8'h05, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd3, 8'h03, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_READ, 2'd1, 8'h00, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_READ, 2'd3, 8'h00, 16'h0000, 8'h00));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 2) || (phase == 5);
      set_pair_load(phase[0]);
      for (int n = 0; n < 270; n++) begin
        send_random_request();
        if ($urandom_range(0, 199) == 0) settle();
      end
      // empty the interrupt queue when it is short, then ask once more
      if (pending_total() <= 300) begin
        while (pending_total() != 0)
          send_request(ctc_req(MODE_ACK, ch_t'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255))));
        send_request(ctc_req(MODE_ACK, 2'd0, 8'h00, 16'h0000, 8'h00));
      end
    end
  endtask

  task automatic test_pending_saturation();
    if (chan_ctl[3][CTL_TC_NEXT])
      send_request(ctc_req(MODE_WRITE, 2'd3, 8'h01, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd3, 8'h95, 16'h0000, 8'h00));
    send_request(ctc_req(MODE_WRITE, 2'd3, 8'h01, 16'h0000, 8'h00));
    repeat (18)
      send_request(ctc_req(MODE_ADVANCE, 2'd3, 8'h00, 16'hffff, 8'($urandom_range(0, 255))));
    repeat (4) send_request(ctc_req(MODE_ACK, 2'd3, 8'h00, 16'h0000, 8'h00));
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (ctc_replies.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        due = ctc_replies.pop_front();
        if (out_tdata[8:0] != due.read_value)
          report_mismatch($sformatf("read_value got %0d want %0d",
                                    out_tdata[8:0], due.read_value));
        if (out_tdata[21:9] != due.zero_crossings)
          report_mismatch($sformatf("zero_crossings got %0d want %0d",
                                    out_tdata[21:9], due.zero_crossings));
        if (out_tdata[29:22] != due.irq_vector)
          report_mismatch($sformatf("irq_vector got %0h want %0h",
                                    out_tdata[29:22], due.irq_vector));
        if (out_tuser != due.irq_valid)
          report_mismatch($sformatf("irq_valid got %0d want %0d", out_tuser, due.irq_valid));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < CHANNELS; k++) begin
      chan_ctl[k]     = 8'h03;
      chan_tc[k]      = TC_FULL;
      chan_residue[k] = '0;
      irq_pending[k]  = '0;
    end
    vec_base  = '0;
    pair_load = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_channel_programming();
    test_paired_load();
    test_random_traffic();
    test_pending_saturation();
    settle();
    repeat (DRAIN_LATENCY) @(posedge clk);
    if (bad_fields == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
